[sv/cpb_pkg.sv]
// Shared types and constants for the clock page buffer.
package cpb_pkg;
  localparam int FRAMES = 16;
  localparam int FIDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int SWEEP_W = $clog2(2 * FRAMES + 1);

  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_UNPIN = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_REPLACE = 3'd2;
  localparam logic [2:0] ST_NOFRAME = 3'd3;
  localparam logic [2:0] ST_UNPIN = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_CLEARED = 3'd6;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] file_id;
    logic [23:0] page_number;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] frame_index;
    logic load_needed;
    logic evicted_valid;
    logic [7:0] evicted_file_id;
    logic [23:0] evicted_page;
    logic [31:0] access_total;
    logic [31:0] hit_total;
    logic [31:0] read_total;
  } rsp_t;

  // Commands from the controller to every frame cell
  typedef struct packed {
    logic write_tag;   // load tag, pin and reference
    logic clr_pin;
    logic clr_ref;
  } cell_cmd_t;
endpackage

[sv/cpb_if.sv]
// Valid/ready channel interfaces for requests and results.
interface cpb_req_if;
  logic valid;
  logic ready;
  cpb_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cpb_rsp_if;
  logic valid;
  logic ready;
  cpb_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[sv/clock_page_buffer_with_pinning_unit.sv]
// Clock page buffer top level: controller, frame cell chain, counters.
// A get with no hit and no free frame sweeps the clock hand at most twice round the m managed frames.
// One request in flight; the next is taken the cycle after the result is taken.
// Synchronous active-low reset clears pin/ref bits, fill count, hand and counters;
// frames_in_use resets to 16. Tags are undefined until loaded.
module clock_page_buffer_with_pinning_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  cpb_req_if.sink     in_req,
  cpb_rsp_if.source   out_rsp
);
  localparam int F = cpb_pkg::FRAMES;
  localparam int IW = cpb_pkg::FIDX_W;
  localparam int CW = cpb_pkg::CNT_W;
  localparam int SW = cpb_pkg::SWEEP_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [4:0] fiu_r;
  cpb_pkg::req_t req_r;
  cpb_pkg::rsp_t rsp_r, rsp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] hand_r, hand_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [31:0] acc_r, acc_nxt, hit_r, hit_nxt, rd_r, rd_nxt;

  // Managed frame count, clamped to 1..F
  logic [CW-1:0] m;
  always_comb begin
    if (fiu_r == 5'd0) m = CW'(1);
    else if ({1'b0, fiu_r} > 6'(F)) m = CW'(F);
    else m = CW'(fiu_r);
  end

  // Cell chain
  cpb_pkg::cell_cmd_t cmd [F];
  logic [F:0] found;
  logic [F-1:0] hit_v, pin_v, ref_v;
  logic [7:0]  tf [F];
  logic [23:0] tp [F];
  assign found[0] = 1'b0;

  for (genvar i = 0; i < F; i++) begin : g_cell
    cpb_cell u_cell (
      .clk, .rst_n,
      .file_id(req_r.file_id), .page_number(req_r.page_number),
      .filled(CW'(i) < fill_r), .cmd(cmd[i]),
      .found_in(found[i]), .found_out(found[i+1]),
      .hit(hit_v[i]), .pin(pin_v[i]), .refb(ref_v[i]),
      .tag_file(tf[i]), .tag_page(tp[i])
    );
  end

  // Encode the single hit position
  logic [IW-1:0] hit_idx;
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < F; i++) if (hit_v[i]) hit_idx = IW'(i);
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  logic [IW-1:0] h_eff, h_next;
  always_comb begin
    h_eff = ({1'b0, hand_r} >= {1'b0, m}) ? '0 : hand_r;
    h_next = ({1'b0, h_eff} + 1'b1 >= {1'b0, m}) ? '0 : IW'(h_eff + 1'b1);
  end

  assign in_req.ready = state_r == S_IDLE;
  assign out_rsp.valid = state_r == S_OUT;
  assign out_rsp.data = rsp_r;

  // Controller
  always_comb begin
    state_nxt = state_r;
    rsp_nxt = rsp_r;
    fill_nxt = fill_r;
    hand_nxt = hand_r;
    steps_nxt = steps_r;
    acc_nxt = acc_r;
    hit_nxt = hit_r;
    rd_nxt = rd_r;
    for (int i = 0; i < F; i++) cmd[i] = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        rsp_nxt = '0;
        rsp_nxt.status = cpb_pkg::ST_NOTFOUND;
        state_nxt = S_OUT;
        priority case (1'b1)
          req_r.opcode == cpb_pkg::OP_GET: begin
            acc_nxt = sat_inc(acc_r);
            if (found[F]) begin
              hit_nxt = sat_inc(hit_r);
              cmd[hit_idx].write_tag = 1'b1;
              rsp_nxt.status = cpb_pkg::ST_HIT;
              rsp_nxt.frame_index = 4'(hit_idx);
            end else if (fill_r < m) begin
              rd_nxt = sat_inc(rd_r);
              cmd[fill_r[IW-1:0]].write_tag = 1'b1;
              fill_nxt = fill_r + 1'b1;
              rsp_nxt.status = cpb_pkg::ST_LOAD;
              rsp_nxt.frame_index = 4'(fill_r[IW-1:0]);
              rsp_nxt.load_needed = 1'b1;
            end else begin
              rsp_nxt.status = cpb_pkg::ST_NOFRAME;
              hand_nxt = h_eff;
              steps_nxt = '0;
              state_nxt = S_SWEEP;
            end
          end
          req_r.opcode == cpb_pkg::OP_UNPIN: begin
            if (found[F]) begin
              cmd[hit_idx].clr_pin = 1'b1;
              rsp_nxt.status = cpb_pkg::ST_UNPIN;
              rsp_nxt.frame_index = 4'(hit_idx);
            end
          end
          req_r.opcode == cpb_pkg::OP_CLEAR: begin
            acc_nxt = '0;
            hit_nxt = '0;
            rd_nxt = '0;
            rsp_nxt.status = cpb_pkg::ST_CLEARED;
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        // One hand step per cycle
        if (steps_r >= SW'({m, 1'b0})) begin
          state_nxt = S_OUT;
        end else begin
          hand_nxt = h_next;
          steps_nxt = steps_r + 1'b1;
          if (ref_v[h_eff]) begin
            cmd[h_eff].clr_ref = 1'b1;
          end else if (!pin_v[h_eff]) begin
            cmd[h_eff].write_tag = 1'b1;
            rd_nxt = sat_inc(rd_r);
            rsp_nxt.status = cpb_pkg::ST_REPLACE;
            rsp_nxt.frame_index = 4'(h_eff);
            rsp_nxt.load_needed = 1'b1;
            rsp_nxt.evicted_valid = 1'b1;
            rsp_nxt.evicted_file_id = tf[h_eff];
            rsp_nxt.evicted_page = tp[h_eff];
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_rsp.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    rsp_nxt.access_total = acc_nxt;
    rsp_nxt.hit_total = hit_nxt;
    rsp_nxt.read_total = rd_nxt;
  end

  // Request capture and result register
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_req.valid) req_r <= in_req.data;
    rsp_r <= rsp_nxt;
    steps_r <= steps_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fiu_r <= 5'd16;
      fill_r <= '0;
      hand_r <= '0;
      acc_r <= '0;
      hit_r <= '0;
      rd_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) fiu_r <= cfg_wdata;
      fill_r <= fill_nxt;
      hand_r <= hand_nxt;
      acc_r <= acc_nxt;
      hit_r <= hit_nxt;
      rd_r <= rd_nxt;
    end
  end
endmodule

[sv/cpb_cell.sv]
// One frame cell: tag, pin and reference bit, tag compare, match chain.
module cpb_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           file_id,
  input  logic [23:0]          page_number,
  input  logic                 filled,
  input  cpb_pkg::cell_cmd_t   cmd,
  input  logic                 found_in,
  output logic                 found_out,
  output logic                 hit,
  output logic                 pin,
  output logic                 refb,
  output logic [7:0]           tag_file,
  output logic [23:0]          tag_page
);
  logic [7:0]  tag_file_r;
  logic [23:0] tag_page_r;
  logic        pin_r, ref_r;

  // Tags, no reset
  always_ff @(posedge clk) begin
    if (cmd.write_tag) begin
      tag_file_r <= file_id;
      tag_page_r <= page_number;
    end
  end

  // Pin and reference bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r <= 1'b0;
      ref_r <= 1'b0;
    end else begin
      if (cmd.write_tag) begin
        pin_r <= 1'b1;
        ref_r <= 1'b1;
      end else begin
        if (cmd.clr_pin) pin_r <= 1'b0;
        if (cmd.clr_ref) ref_r <= 1'b0;
      end
    end
  end

  // Lowest match wins: hit only if no lower cell matched
  logic match;
  assign match = filled && tag_file_r == file_id && tag_page_r == page_number;
  assign hit = match && !found_in;
  assign found_out = match || found_in;
  assign pin = pin_r;
  assign refb = ref_r;
  assign tag_file = tag_file_r;
  assign tag_page = tag_page_r;
endmodule

[test/tb_scoreboard.sv]
// Page buffer scoreboard: clock replacement predictor and expected-result queue.
`timescale 1ns / 100ps
class cpb_scoreboard;
  logic [7:0] tag_file[16];
  logic [23:0] tag_page[16];
  bit pin[16];
  bit refb[16];
  int unsigned fill;
  int unsigned hand;
  logic [31:0] acc_cnt, hit_cnt, rd_cnt;
  logic [4:0] frames_cfg;
  cpb_pkg::rsp_t pending_rsp[$];
  int errors;

  function new();
    foreach (tag_file[i]) begin
      tag_file[i] = '0;
      tag_page[i] = '0;
      pin[i] = 0;
      refb[i] = 0;
    end
    fill = 0;
    hand = 0;
    acc_cnt = '0;
    hit_cnt = '0;
    rd_cnt = '0;
    frames_cfg = 5'd16;
    errors = 0;
  endfunction

  function void set_frames(logic [4:0] v);
    frames_cfg = v;
  endfunction

  function int find_frame(logic [7:0] f, logic [23:0] p);
    for (int i = 0; i < 16; i++)
      if (i < fill && tag_file[i] == f && tag_page[i] == p) return i;
    return -1;
  endfunction

  // Predict one request's result and queue it
  function void note_request(cpb_pkg::req_t r);
    cpb_pkg::rsp_t e;
    int k;
    int unsigned m;
    int unsigned h;
    m = frames_cfg < 1 ? 1 : (frames_cfg > 16 ? 16 : frames_cfg);
    e = '0;
    e.status = cpb_pkg::ST_NOTFOUND;
    if (r.opcode == cpb_pkg::OP_GET) begin
      k = find_frame(r.file_id, r.page_number);
      if (acc_cnt != '1) acc_cnt++;
      if (k >= 0) begin
        refb[k] = 1;
        pin[k] = 1;
        if (hit_cnt != '1) hit_cnt++;
        e.status = cpb_pkg::ST_HIT;
        e.frame_index = 4'(k);
      end else if (fill < m) begin
        tag_file[fill] = r.file_id;
        tag_page[fill] = r.page_number;
        pin[fill] = 1;
        refb[fill] = 1;
        if (rd_cnt != '1) rd_cnt++;
        e.status = cpb_pkg::ST_LOAD;
        e.frame_index = 4'(fill);
        e.load_needed = 1;
        fill++;
      end else begin
        e.status = cpb_pkg::ST_NOFRAME;
        if (hand >= m) hand = 0;
        for (int s = 0; s < 2 * m; s++) begin
          h = hand;
          hand = (h + 1) % m;
          if (refb[h]) refb[h] = 0;
          else if (!pin[h]) begin
            e.evicted_valid = 1;
            e.evicted_file_id = tag_file[h];
            e.evicted_page = tag_page[h];
            tag_file[h] = r.file_id;
            tag_page[h] = r.page_number;
            pin[h] = 1;
            refb[h] = 1;
            if (rd_cnt != '1) rd_cnt++;
            e.status = cpb_pkg::ST_REPLACE;
            e.frame_index = 4'(h);
            e.load_needed = 1;
            break;
          end
        end
      end
    end else if (r.opcode == cpb_pkg::OP_UNPIN) begin
      k = find_frame(r.file_id, r.page_number);
      if (k >= 0) begin
        pin[k] = 0;
        e.status = cpb_pkg::ST_UNPIN;
        e.frame_index = 4'(k);
      end
    end else if (r.opcode == cpb_pkg::OP_CLEAR) begin
      acc_cnt = '0;
      hit_cnt = '0;
      rd_cnt = '0;
      e.status = cpb_pkg::ST_CLEARED;
    end
    e.access_total = acc_cnt;
    e.hit_total = hit_cnt;
    e.read_total = rd_cnt;
    pending_rsp.push_back(e);
  endfunction

  // Compare one result with the oldest expectation
  function void check_result(cpb_pkg::rsp_t a);
    cpb_pkg::rsp_t e;
    if (pending_rsp.size() == 0) begin
      $display("%0t: unexpected result %h", $time, a);
      errors++;
      return;
    end
    e = pending_rsp.pop_front();
    if (a.status !== e.status) begin
      $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
      errors++;
    end
    if (a.frame_index !== e.frame_index) begin
      $display("%0t: frame_index exp %0d got %0d", $time, e.frame_index, a.frame_index);
      errors++;
    end
    if (a.load_needed !== e.load_needed) begin
      $display("%0t: load_needed exp %0d got %0d", $time, e.load_needed, a.load_needed);
      errors++;
    end
    if (a.evicted_valid !== e.evicted_valid) begin
      $display("%0t: evicted_valid exp %0d got %0d", $time, e.evicted_valid,
               a.evicted_valid);
      errors++;
    end
    if (a.evicted_file_id !== e.evicted_file_id) begin
      $display("%0t: evicted_file_id exp %h got %h", $time, e.evicted_file_id,
               a.evicted_file_id);
      errors++;
    end
    if (a.evicted_page !== e.evicted_page) begin
      $display("%0t: evicted_page exp %h got %h", $time, e.evicted_page, a.evicted_page);
      errors++;
    end
    if (a.access_total !== e.access_total) begin
      $display("%0t: access_total exp %0d got %0d", $time, e.access_total,
               a.access_total);
      errors++;
    end
    if (a.hit_total !== e.hit_total) begin
      $display("%0t: hit_total exp %0d got %0d", $time, e.hit_total, a.hit_total);
      errors++;
    end
    if (a.read_total !== e.read_total) begin
      $display("%0t: read_total exp %0d got %0d", $time, e.read_total, a.read_total);
      errors++;
    end
  endfunction
endclass

[test/tb.sv]
// Testbench top: drives page requests and checks results against the scoreboard.
`timescale 1ns / 100ps
module tb;
  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [4:0] cfg_wdata;
  cpb_req_if in_req();
  cpb_rsp_if out_rsp();
  cpb_scoreboard sb;
  int burst_left;

  clock_page_buffer_with_pinning_unit u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_req(in_req.sink), .out_rsp(out_rsp.source)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #50_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Receiver: stall pattern and result checking
  initial begin
    out_rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_rsp.valid && out_rsp.ready) sb.check_result(out_rsp.data);
      case ($urandom_range(0, 3))
        0: out_rsp.ready <= 1'b0;
        default: out_rsp.ready <= 1'b1;
      endcase
    end
  end

  // Send one request, with bursty gaps before it
  task automatic send_request(cpb_pkg::req_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
    burst_left--;
    in_req.valid <= 1'b1;
    in_req.data <= r;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(r);
    in_req.valid <= 1'b0;
    // Ready stays low while the request is served
    @(posedge clk);
  endtask

  task automatic send_fields(logic [1:0] op, logic [7:0] f, logic [23:0] p);
    cpb_pkg::req_t r;
    r.opcode = op;
    r.file_id = f;
    r.page_number = p;
    send_request(r);
  endtask

  // Drain, wait out a sweep, then write frames_in_use
  task automatic set_frames(logic [4:0] v);
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_frames(v);
  endtask

  // Random phase: small page pool so hits and pinning matter
  task automatic random_phase(int n);
    logic [1:0] op;
    logic [7:0] f;
    logic [23:0] p;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: op = cpb_pkg::OP_CLEAR;
        1: op = cpb_pkg::OP_UNUSED;
        2, 3, 4, 5, 6, 7, 8: op = cpb_pkg::OP_UNPIN;
        default: op = cpb_pkg::OP_GET;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        f = 8'($urandom);
        p = 24'($urandom);
      end else begin
        f = $urandom_range(0, 3) == 0 ? 8'hFF : 8'h00;
        p = 24'($urandom_range(0, 23));
        if (p[4]) p = 24'hFFFFF0 | p[3:0];
      end
      send_fields(op, f, p);
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 5'd16;
    in_req.valid = 1'b0;
    in_req.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill, hit, duplicate-free pinning, all pinned, unpin, replace
    set_frames(5'd2);
    send_fields(cpb_pkg::OP_GET, 8'h00, 24'h000000);
    send_fields(cpb_pkg::OP_GET, 8'hFF, 24'hFFFFFF);
    send_fields(cpb_pkg::OP_GET, 8'h00, 24'h000000);
    send_fields(cpb_pkg::OP_GET, 8'h12, 24'h345678);
    send_fields(cpb_pkg::OP_UNPIN, 8'h55, 24'h000001);
    send_fields(cpb_pkg::OP_UNPIN, 8'h00, 24'h000000);
    send_fields(cpb_pkg::OP_GET, 8'h12, 24'h345678);
    send_fields(cpb_pkg::OP_GET, 8'hFF, 24'hFFFFFF);
    send_fields(cpb_pkg::OP_UNUSED, 8'hAA, 24'hAAAAAA);
    send_fields(cpb_pkg::OP_CLEAR, 8'h00, 24'h000000);
    // Shrunk frame count: lookups still see filled frames beyond m
    set_frames(5'd0);
    send_fields(cpb_pkg::OP_GET, 8'hFF, 24'hFFFFFF);
    send_fields(cpb_pkg::OP_UNPIN, 8'h12, 24'h345678);
    send_fields(cpb_pkg::OP_GET, 8'h01, 24'h000002);
    set_frames(5'd31);
    send_fields(cpb_pkg::OP_GET, 8'h01, 24'h000003);
    send_fields(cpb_pkg::OP_UNPIN, 8'h01, 24'h000003);

    random_phase(300);
    set_frames(5'd1);
    random_phase(150);
    set_frames(5'd16);
    random_phase(300);
    set_frames(5'd5);
    random_phase(250);
    set_frames(5'd17);
    random_phase(250);

    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
